// ----- sv/sprite_frame_sequencer_unit_macros.svh -----
// Assertion macros for the sprite frame sequencer.
// Included by the top level; needs a clock and an active-low reset in scope.
`ifndef SPRITE_FRAME_SEQUENCER_UNIT_MACROS_SVH
`define SPRITE_FRAME_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define SFS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define SFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/sfs_pkg.sv -----
// Shared types and constants for the sprite frame sequencer.
// No dependencies; imported by sfs_div and the top level.
`timescale 1ns / 1ps

package sfs_pkg;

    // Field widths
    localparam int PERIOD_W = 24;
    localparam int COUNT_W  = 9;
    localparam int PIX_W    = 12;
    localparam int FRAME_W  = 8;
    localparam int DELTA_W  = 16;
    localparam int SY_W     = 25;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    // Divider operand width: start_frame + frame needs 13 bits
    localparam int DIV_W   = 13;
    localparam int DIV_CNT_W = 4;

    localparam logic [PERIOD_W-1:0] TIMER_MAX = 24'hFFFFFF;
    localparam logic [COUNT_W-1:0]  MAX_COUNT = 9'd256;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_FRAME  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHEET_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT  = 3'd6;

    // Divider request from the sequencer
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    // Divider status and result
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } t_div_stat;

endpackage

// ----- sv/sfs_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on sfs_pkg for widths and the request/status structs.
`timescale 1ns / 1ps

module sfs_div
    import sfs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_req  i_req,
    output t_div_stat o_stat
);

    logic [DIV_W:0]     r_rem;
    logic [DIV_W-1:0]   r_quo;
    logic [DIV_W-1:0]   r_divisor;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [DIV_W:0] w_shift;
    logic [DIV_W:0] w_diff;

    // Trial subtract of the shifted partial remainder
    always_comb begin
        w_shift = {r_rem[DIV_W-1:0], r_quo[DIV_W-1]};
        w_diff  = w_shift - {1'b0, r_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy    <= 1'b1;
                r_cnt     <= DIV_CNT_W'(DIV_W);
                r_quo     <= i_req.dividend;
                r_divisor <= i_req.divisor;
                r_rem     <= '0;
            end else if (r_busy) begin
                if (w_diff[DIV_W]) begin
                    r_rem <= w_shift;
                    r_quo <= {r_quo[DIV_W-2:0], 1'b0};
                end else begin
                    r_rem <= w_diff;
                    r_quo <= {r_quo[DIV_W-2:0], 1'b1};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy      = r_busy;
    assign o_stat.done      = r_done;
    assign o_stat.quotient  = r_quo;
    assign o_stat.remainder = r_rem[DIV_W-1:0];

endmodule

// ----- sv/sprite_frame_sequencer_unit.sv -----
// Each accepted tick runs a timer update, two divides on the shared divider, two
// shared-multiplier steps, a divider start and an output load; the per-row divide is
// skipped when the cell width is zero.
// A new tick is accepted only once the previous one has reached the output register; a
// result not yet taken from the output register stalls the next tick at its load.
// Reset (synchronous, active low): timer 0, frame 0, playing, registers to defaults.
`timescale 1ns / 1ps
`include "sprite_frame_sequencer_unit_macros.svh"

module sprite_frame_sequencer_unit
    import sfs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // tick input
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [DELTA_W-1:0]    i_delta_time,
    // result output
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [FRAME_W-1:0]    o_frame_index,
    output logic                  o_playing,
    output logic [PIX_W-1:0]      o_source_x,
    output logic [SY_W-1:0]       o_source_y
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD,
        S_WAIT_ROW,
        S_DIV_POS,
        S_WAIT_POS,
        S_MUL_X,
        S_MUL_Y,
        S_OUT
    } t_state;

    // Configuration registers
    logic [PERIOD_W-1:0] r_frame_period;
    logic [COUNT_W-1:0]  r_frame_count;
    logic                r_loop_enable;
    logic [PIX_W-1:0]    r_start_frame;
    logic [PIX_W-1:0]    r_sheet_width;
    logic [PIX_W-1:0]    r_cell_width;
    logic [PIX_W-1:0]    r_cell_height;

    // Animation state and working registers
    t_state              r_state, n_state;
    logic [PERIOD_W-1:0] r_elapsed, n_elapsed;
    logic [FRAME_W-1:0]  r_frame, n_frame;
    logic                r_play, n_play;
    logic [DELTA_W-1:0]  r_delta;
    logic [PIX_W-1:0]    r_per_row, n_per_row;
    logic [DIV_W-1:0]    r_col, n_col;
    logic [DIV_W-1:0]    r_row, n_row;
    logic [PIX_W-1:0]    r_sx, n_sx;
    logic [SY_W-1:0]     r_sy, n_sy;

    // Output register
    logic                r_out_valid, n_out_valid;
    logic [FRAME_W-1:0]  r_o_frame, n_o_frame;
    logic                r_o_play, n_o_play;
    logic [PIX_W-1:0]    r_o_sx, n_o_sx;
    logic [SY_W-1:0]     r_o_sy, n_o_sy;

    t_div_req  w_div_req;
    t_div_stat w_div_stat;

    logic [SY_W-1:0]     w_mul_a;
    logic [SY_W-1:0]     w_mul_b;
    logic [SY_W-1:0]     w_mul_p;

    logic [PERIOD_W:0]   w_sum;
    logic [PERIOD_W-1:0] w_sat;
    logic [COUNT_W-1:0]  w_count;
    logic [COUNT_W-1:0]  w_next;
    logic [DIV_W-1:0]    w_global;
    logic                w_in_acc;

    assign w_in_acc = i_in_valid && o_in_ready;

    // Configuration writes; out-of-range indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_period <= PERIOD_W'(1000);
            r_frame_count  <= COUNT_W'(1);
            r_loop_enable  <= 1'b1;
            r_start_frame  <= '0;
            r_sheet_width  <= PIX_W'(256);
            r_cell_width   <= PIX_W'(32);
            r_cell_height  <= PIX_W'(32);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_PERIOD: r_frame_period <= i_cfg_data[PERIOD_W-1:0];
                CFG_FRAME_COUNT:  r_frame_count  <= i_cfg_data[COUNT_W-1:0];
                CFG_LOOP_ENABLE:  r_loop_enable  <= i_cfg_data[0];
                CFG_START_FRAME:  r_start_frame  <= i_cfg_data[PIX_W-1:0];
                CFG_SHEET_WIDTH:  r_sheet_width  <= i_cfg_data[PIX_W-1:0];
                CFG_CELL_WIDTH:   r_cell_width   <= i_cfg_data[PIX_W-1:0];
                CFG_CELL_HEIGHT:  r_cell_height  <= i_cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // Timer add with saturation and effective frame count
    always_comb begin
        w_sum = {1'b0, r_elapsed} + {{(PERIOD_W+1-DELTA_W){1'b0}}, r_delta};
        w_sat = w_sum[PERIOD_W] ? TIMER_MAX : w_sum[PERIOD_W-1:0];
        if (r_frame_count == '0) begin
            w_count = COUNT_W'(1);
        end else if (r_frame_count > MAX_COUNT) begin
            w_count = MAX_COUNT;
        end else begin
            w_count = r_frame_count;
        end
        w_next   = {1'b0, r_frame} + COUNT_W'(1);
        w_global = {1'b0, r_start_frame} + {{(DIV_W-FRAME_W){1'b0}}, r_frame};
    end

    // Shared multiplier: column by cell width, then row by cell height
    always_comb begin
        if (r_state == S_MUL_Y) begin
            w_mul_a = SY_W'(r_row);
            w_mul_b = SY_W'(r_cell_height);
        end else begin
            w_mul_a = SY_W'(r_col);
            w_mul_b = SY_W'(r_cell_width);
        end
        w_mul_p = w_mul_a * w_mul_b;
    end

    // Divider requests: sheet/cell for per-row, then global index/per-row
    always_comb begin
        w_div_req.start    = 1'b0;
        w_div_req.dividend = {1'b0, r_sheet_width};
        w_div_req.divisor  = {1'b0, r_cell_width};
        if (r_state == S_UPD && r_cell_width != '0) begin
            w_div_req.start = 1'b1;
        end else if (r_state == S_DIV_POS) begin
            w_div_req.start    = 1'b1;
            w_div_req.dividend = w_global;
            w_div_req.divisor  = {1'b0, r_per_row};
        end
    end

    sfs_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_div_req),
        .o_stat (w_div_stat)
    );

    // Sequencer next-state logic
    always_comb begin
        n_state     = r_state;
        n_elapsed   = r_elapsed;
        n_frame     = r_frame;
        n_play      = r_play;
        n_per_row   = r_per_row;
        n_col       = r_col;
        n_row       = r_row;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_out_valid = r_out_valid && !i_out_ready;
        n_o_frame   = r_o_frame;
        n_o_play    = r_o_play;
        n_o_sx      = r_o_sx;
        n_o_sy      = r_o_sy;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (r_play) begin
                    if (w_sat >= r_frame_period) begin
                        n_elapsed = '0;
                        if (w_next >= w_count) begin
                            if (r_loop_enable) begin
                                n_frame = '0;
                            end else begin
                                n_frame = FRAME_W'(w_count - COUNT_W'(1));
                                n_play  = 1'b0;
                            end
                        end else begin
                            n_frame = w_next[FRAME_W-1:0];
                        end
                    end else begin
                        n_elapsed = w_sat;
                    end
                end
                if (r_cell_width == '0) begin
                    n_per_row = PIX_W'(1);
                    n_state   = S_DIV_POS;
                end else begin
                    n_state = S_WAIT_ROW;
                end
            end
            S_WAIT_ROW: begin
                if (w_div_stat.done) begin
                    n_per_row = (w_div_stat.quotient == '0) ? PIX_W'(1)
                                                            : w_div_stat.quotient[PIX_W-1:0];
                    n_state   = S_DIV_POS;
                end
            end
            S_DIV_POS: begin
                n_state = S_WAIT_POS;
            end
            S_WAIT_POS: begin
                if (w_div_stat.done) begin
                    n_col   = w_div_stat.remainder;
                    n_row   = w_div_stat.quotient;
                    n_state = S_MUL_X;
                end
            end
            S_MUL_X: begin
                n_sx    = w_mul_p[PIX_W-1:0];
                n_state = S_MUL_Y;
            end
            S_MUL_Y: begin
                n_sy    = w_mul_p;
                n_state = S_OUT;
            end
            S_OUT: begin
                // load only when the output register is free this cycle
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_frame   = r_frame;
                    n_o_play    = r_play;
                    n_o_sx      = r_sx;
                    n_o_sy      = r_sy;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_elapsed   <= '0;
            r_frame     <= '0;
            r_play      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_elapsed   <= n_elapsed;
            r_frame     <= n_frame;
            r_play      <= n_play;
            r_out_valid <= n_out_valid;
        end
        if (w_in_acc) begin
            r_delta <= i_delta_time;
        end
        r_per_row <= n_per_row;
        r_col     <= n_col;
        r_row     <= n_row;
        r_sx      <= n_sx;
        r_sy      <= n_sy;
        r_o_frame <= n_o_frame;
        r_o_play  <= n_o_play;
        r_o_sx    <= n_o_sx;
        r_o_sy    <= n_o_sy;
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_frame_index = r_o_frame;
    assign o_playing     = r_o_play;
    assign o_source_x    = r_o_sx;
    assign o_source_y    = r_o_sy;

    // Checks
    `SFS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_acc, !o_in_ready, "ready after accept")
    `SFS_ASSERT_NOW(a_div_done_waited, i_clk, i_rst_n, w_div_stat.done, (r_state == S_WAIT_ROW || r_state == S_WAIT_POS), "divide result unclaimed")
    `SFS_ASSERT_NEXT(a_stop_sticks, i_clk, i_rst_n, !r_play, !r_play, "play resumed without reset")

endmodule
